### rtl/fsdp_pkg.sv
// ----------------------------------------------------------------------------
// fsdp_pkg: shared constants of the signed-decimal format printer
// Character codes, field widths and parameter defaults used by the printer.
// ----------------------------------------------------------------------------
package fsdp_pkg;

    localparam int CHAR_W     = 8;
    localparam int ARG_W      = 32;
    localparam int COUNT_W    = 31;
    localparam int IN_TDATA_W  = 40;  // format_char + argument
    localparam int OUT_TDATA_W = 40;  // out_char + total_length + format_error

    localparam int DEFAULT_VALUE_BITS = 32;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_D = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_I = 8'h69;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;

endpackage

### rtl/format_string_decimal_printer_top.sv
// ----------------------------------------------------------------------------
// format_string_decimal_printer_top: printf subset with %d, %i and %%
// Echoes format characters, expands signed decimal conversions one digit per
// transaction and closes each format with a status transaction.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): one format character per transaction with the
//   argument that a %d or %i ending on it consumes; tlast marks the end of
//   the format, and a zero character with tlast set only closes the format.
//   Output stream (m_axis_*): one printed character per transaction with the
//   running saturating count; tlast marks the last transaction caused by one
//   input transaction, and tuser marks the closing status transaction with
//   the final count and the error flag for a format ending on a lone '%'.
// Sequencing
//   One item is handled at a time. A plain character or '%%' is emitted from
//   the emit state, after which the next item is taken; an unknown
//   conversion emits '%' and then the character. A %d or %i shifts
//   VALUE_BITS bits through a binary to BCD converter, emits '-' for a
//   negative value and then walks all NUM_DIGITS digits one per cycle while
//   the output is free, dropping leading zeros. A status transaction follows
//   when the item ends the format.
// Reset and stall
//   Reset clears the pending '%', the count and the output valid. While
//   m_axis_tready is low the output register holds and the sequencer waits;
//   s_axis_tready stays low until the item has pushed all its results.
// ----------------------------------------------------------------------------
module format_string_decimal_printer_top #(
    parameter int VALUE_BITS = fsdp_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] format_char, [39:8] argument
    input  logic [fsdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,   // end_of_format
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] out_char, [38:8] total_length, [39] format_error
    output logic [fsdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,   // last_of_run
    output logic                             m_axis_tuser    // is_status
);

    // Decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103).
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EMIT   = 3'd1;
    localparam logic [2:0] ST_CONV   = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIGIT  = 3'd4;
    localparam logic [2:0] ST_STATUS = 3'd5;

    // Control state.
    logic [2:0]                     state_reg, state_next;
    logic                           pending_reg, pending_next;
    logic [fsdp_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                           two_reg, two_next;
    logic                           end_reg, end_next;
    logic                           neg_reg, neg_next;
    logic                           started_reg, started_next;
    logic [BIT_CNT_W-1:0]           bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]           dig_cnt_reg, dig_cnt_next;
    logic                           m_valid_reg, m_valid_next;

    // Payload.
    logic [fsdp_pkg::CHAR_W-1:0]    ch_reg, ch_next;
    logic [VALUE_BITS-1:0]          mag_reg, mag_next;
    logic [BCD_W-1:0]               bcd_reg, bcd_next;
    logic [fsdp_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;
    logic                           m_user_reg, m_user_next;

    // Input fields.
    logic [fsdp_pkg::CHAR_W-1:0]    in_char;
    logic [fsdp_pkg::ARG_W-1:0]     in_arg;
    logic [63:0]                    arg_ext;
    logic [VALUE_BITS-1:0]          in_value;
    logic                           in_neg;

    // Output push request from the sequencer.
    logic                           out_free;
    logic                           push_char;
    logic                           push_status;
    logic [fsdp_pkg::CHAR_W-1:0]    push_ch;
    logic                           push_last;
    logic [fsdp_pkg::COUNT_W-1:0]   count_inc;

    logic [BCD_W-1:0]               bcd_adj;
    logic [3:0]                     top_digit;
    logic                           show_digit;
    logic                           accept;

    assign in_char  = s_axis_tdata[7:0];
    assign in_arg   = s_axis_tdata[39:8];
    assign arg_ext  = {{32{in_arg[fsdp_pkg::ARG_W-1]}}, in_arg};
    assign in_value = arg_ext[VALUE_BITS-1:0];
    assign in_neg   = in_value[VALUE_BITS-1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign count_inc = (count_reg == fsdp_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + 31'd1;

    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign show_digit = started_reg || (top_digit != 4'd0) ||
                        (dig_cnt_reg == DIG_CNT_W'(1));

    // Double-dabble correction: each BCD digit of five or more gets three
    // added so that the following left shift carries into the next digit.
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        two_next     = two_reg;
        end_next     = end_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        ch_next      = ch_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        push_char    = 1'b0;
        push_status  = 1'b0;
        push_ch      = fsdp_pkg::CHAR_NUL;
        push_last    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next  = in_char;
                    end_next = s_axis_tlast;
                    two_next = 1'b0;
                    if (in_char == fsdp_pkg::CHAR_NUL)
                    begin
                        state_next = s_axis_tlast ? ST_STATUS : ST_IDLE;
                    end
                    else if (!pending_reg)
                    begin
                        if (in_char == fsdp_pkg::CHAR_PERCENT)
                        begin
                            pending_next = 1'b1;
                            state_next   = s_axis_tlast ? ST_STATUS : ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        if (in_char == fsdp_pkg::CHAR_PERCENT)
                        begin
                            state_next = ST_EMIT;
                        end
                        else if (in_char == fsdp_pkg::CHAR_LOWER_D ||
                                 in_char == fsdp_pkg::CHAR_LOWER_I)
                        begin
                            neg_next     = in_neg;
                            mag_next     = in_neg ? (~in_value + VALUE_BITS'(1))
                                                  : in_value;
                            bcd_next     = '0;
                            bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
                            state_next   = ST_CONV;
                        end
                        else
                        begin
                            // Unknown conversion: '%' then the character.
                            two_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    push_char = 1'b1;
                    if (two_reg)
                    begin
                        push_ch  = fsdp_pkg::CHAR_PERCENT;
                        two_next = 1'b0;
                    end
                    else
                    begin
                        push_ch    = ch_reg;
                        push_last  = !end_reg;
                        state_next = end_reg ? ST_STATUS : ST_IDLE;
                    end
                end
            end

            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end

            ST_SIGN:
            begin
                if (out_free)
                begin
                    push_char  = 1'b1;
                    push_ch    = fsdp_pkg::CHAR_MINUS;
                    state_next = ST_DIGIT;
                end
            end

            ST_DIGIT:
            begin
                // Leading zeros are dropped one per cycle without output.
                if (!show_digit || out_free)
                begin
                    if (show_digit)
                    begin
                        push_char    = 1'b1;
                        push_ch      = fsdp_pkg::CHAR_ZERO + {4'd0, top_digit};
                        push_last    = (dig_cnt_reg == DIG_CNT_W'(1)) && !end_reg;
                        started_next = 1'b1;
                    end
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                        state_next = end_reg ? ST_STATUS : ST_IDLE;
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    push_status  = 1'b1;
                    push_last    = 1'b1;
                    pending_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register and running count.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        count_next   = count_reg;
        if (push_char)
        begin
            count_next   = count_inc;
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, count_inc, push_ch};
            m_last_next  = push_last;
            m_user_next  = 1'b0;
        end
        else if (push_status)
        begin
            count_next   = '0;
            m_valid_next = 1'b1;
            m_data_next  = {pending_reg, count_reg, fsdp_pkg::CHAR_NUL};
            m_last_next  = 1'b1;
            m_user_next  = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            two_reg     <= 1'b0;
            end_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            started_reg <= 1'b0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            two_reg     <= two_next;
            end_reg     <= end_next;
            neg_reg     <= neg_next;
            started_reg <= started_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // A status transaction closes its run and carries no character.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg) |-> (m_last_reg && m_data_reg[7:0] == 8'h00))
        else $error("status transaction without tlast or with a character");

    // The count restarts after a status transaction is pushed.
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push_status |=> (count_reg == '0 && !pending_reg))
        else $error("count or pending percent not cleared after status");

    // The count never falls within a format.
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !push_status |=> (count_reg >= $past(count_reg)))
        else $error("printed count decreased within a format");

    // Digits walked out of the converter are decimal.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (top_digit <= 4'd9))
        else $error("BCD digit out of range");

    // A stalled output transaction stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=>
            (m_valid_reg && $stable(m_data_reg) && $stable(m_last_reg) &&
             $stable(m_user_reg)))
        else $error("stalled output transaction changed or dropped");

endmodule
